FILE: sv/deq_pkg.sv
`default_nettype none
package deq_pkg;

   localparam int DEPTH = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int KIND_W = 3;
   localparam int POS_W = 4;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_READ = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT_FRONT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND_BACK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_FRONT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE_BACK = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: sv/deq_cell.sv
`default_nettype none
module deq_cell (
   input  wire                                 clock,
   input  wire deq_pkg::cell_ctrl_type         ctrl,
   input  wire [deq_pkg::WORD_WIDTH-1:0]       from_front,
   input  wire [deq_pkg::WORD_WIDTH-1:0]       from_back,
   input  wire [deq_pkg::WORD_WIDTH-1:0]       load_word,
   output logic [deq_pkg::WORD_WIDTH-1:0]      word
);

   logic [deq_pkg::WORD_WIDTH-1:0] word_ff;
   logic [deq_pkg::WORD_WIDTH-1:0] word_in;

   always_comb begin
      priority if (ctrl.shift_in) begin
         word_in = from_front;
      end else if (ctrl.shift_out) begin
         word_in = from_back;
      end else if (ctrl.load) begin
         word_in = load_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
`default_nettype wire

FILE: sv/double_ended_queue_indexed_core.sv
// A result is registered and shown in the cycle after its request transfer.
// Throughput: one request per cycle unless a response stalls; each operation
// finishes in one pass through the cell row, which shifts one place or loads
// one cell per cycle. Reset (synchronous, active high) empties the queue and
// clears the response valid; stored words are kept and never read unwritten.
`default_nettype none
module double_ended_queue_indexed_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire [deq_pkg::KIND_W-1:0]           req_kind,
   input  wire [deq_pkg::WORD_WIDTH-1:0]       req_value,
   input  wire [deq_pkg::POS_W-1:0]            req_position,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [deq_pkg::WORD_WIDTH-1:0]      rsp_read_word,
   output logic [deq_pkg::COUNT_W-1:0]         rsp_occupancy
);

   logic                             req_fire;
   logic                             full;
   logic                             empty;
   logic [deq_pkg::COUNT_W-1:0]      count_ff;
   logic [deq_pkg::COUNT_W-1:0]      count_in;
   logic [deq_pkg::STATUS_W-1:0]     status_in;
   logic [deq_pkg::WORD_WIDTH-1:0]   word_in;
   logic                             do_insert;
   logic                             do_append;
   logic                             do_remove_front;
   logic                             rsp_valid_ff;
   logic [deq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [deq_pkg::WORD_WIDTH-1:0]   rsp_word_ff;
   logic [deq_pkg::COUNT_W-1:0]      rsp_occ_ff;
   logic [deq_pkg::WORD_WIDTH-1:0]   cell_word [deq_pkg::DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign full = (count_ff == deq_pkg::COUNT_W'(deq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      status_in = deq_pkg::ST_OK;
      word_in = '0;
      do_insert = 1'b0;
      do_append = 1'b0;
      do_remove_front = 1'b0;
      unique case (req_kind)
         deq_pkg::KIND_READ: begin
            if (deq_pkg::COUNT_W'(req_position) < count_ff) begin
               word_in = cell_word[req_position[deq_pkg::IDX_W-1:0]];
            end else begin
               status_in = deq_pkg::ST_RANGE;
            end
         end
         deq_pkg::KIND_INSERT_FRONT: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               do_insert = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::KIND_APPEND_BACK: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               do_append = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::KIND_REMOVE_FRONT: begin
            if (empty) begin
               status_in = deq_pkg::ST_RANGE;
            end else begin
               do_remove_front = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::KIND_REMOVE_BACK: begin
            if (empty) begin
               status_in = deq_pkg::ST_RANGE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = deq_pkg::ST_RANGE;
         end
      endcase
   end

   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      deq_pkg::cell_ctrl_type          ctrl;
      logic [deq_pkg::WORD_WIDTH-1:0]  from_front;
      logic [deq_pkg::WORD_WIDTH-1:0]  from_back;

      assign ctrl.shift_in = req_fire && do_insert;
      assign ctrl.shift_out = req_fire && do_remove_front;
      assign ctrl.load = req_fire && do_append && (count_ff == deq_pkg::COUNT_W'(i));

      if (i == 0) begin : g_head
         assign from_front = req_value;
      end else begin : g_body
         assign from_front = cell_word[i-1];
      end
      if (i == deq_pkg::DEPTH - 1) begin : g_tail
         assign from_back = '0;
      end else begin : g_link
         assign from_back = cell_word[i+1];
      end

      deq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .from_front (from_front),
         .from_back  (from_back),
         .load_word  (req_value),
         .word       (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status_in;
         rsp_word_ff <= word_in;
         rsp_occ_ff <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
      else $error("occupancy beyond depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == deq_pkg::ST_FULL
         |-> rsp_occupancy == deq_pkg::COUNT_W'(deq_pkg::DEPTH))
      else $error("full status while not full");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != deq_pkg::ST_OK |-> rsp_read_word == '0)
      else $error("nonzero word on failed request");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a transfer");

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam logic [deq_pkg::KIND_W-1:0] KIND_UNUSED_LO = deq_pkg::KIND_REMOVE_BACK + 1'b1;
   localparam logic [deq_pkg::KIND_W-1:0] KIND_UNUSED_HI = '1;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [deq_pkg::STATUS_W-1:0]   status;
      logic [deq_pkg::WORD_WIDTH-1:0] read_word;
      logic [deq_pkg::COUNT_W-1:0]    occupancy;
   } reply_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [deq_pkg::KIND_W-1:0]     req_kind = deq_pkg::KIND_READ;
   logic [deq_pkg::WORD_WIDTH-1:0] req_value = '0;
   logic [deq_pkg::POS_W-1:0]      req_position = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [deq_pkg::STATUS_W-1:0]   rsp_status;
   logic [deq_pkg::WORD_WIDTH-1:0] rsp_read_word;
   logic [deq_pkg::COUNT_W-1:0]    rsp_occupancy;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic [deq_pkg::WORD_WIDTH-1:0] shadow_store [deq_pkg::DEPTH];
   logic [deq_pkg::IDX_W-1:0]      shadow_front = '0;
   logic [deq_pkg::COUNT_W-1:0]    shadow_count = '0;
   logic [deq_pkg::IDX_W-1:0]      shadow_slot;
   reply_type                      predicted;
   reply_type                      observed;
   reply_type                      expected_replies [$];

   double_ended_queue_indexed_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_read_word (rsp_read_word),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic compare_field(input string field,
                                input logic [deq_pkg::WORD_WIDTH-1:0] want,
                                input logic [deq_pkg::WORD_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // Requests are predicted before responses are checked, so ordering holds
   // even if a response ever came in the cycle of its request.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predicted.status = deq_pkg::ST_OK;
         predicted.read_word = '0;
         case (req_kind)
            deq_pkg::KIND_READ: begin
               if (deq_pkg::COUNT_W'(req_position) < shadow_count) begin
                  shadow_slot = shadow_front + req_position;
                  predicted.read_word = shadow_store[shadow_slot];
               end else begin
                  predicted.status = deq_pkg::ST_RANGE;
               end
            end
            deq_pkg::KIND_INSERT_FRONT: begin
               if (shadow_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH)) begin
                  predicted.status = deq_pkg::ST_FULL;
               end else begin
                  shadow_front = shadow_front - 1'b1;
                  shadow_store[shadow_front] = req_value;
                  shadow_count = shadow_count + 1'b1;
               end
            end
            deq_pkg::KIND_APPEND_BACK: begin
               if (shadow_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH)) begin
                  predicted.status = deq_pkg::ST_FULL;
               end else begin
                  shadow_slot = shadow_front + shadow_count[deq_pkg::IDX_W-1:0];
                  shadow_store[shadow_slot] = req_value;
                  shadow_count = shadow_count + 1'b1;
               end
            end
            deq_pkg::KIND_REMOVE_FRONT: begin
               if (shadow_count == '0) begin
                  predicted.status = deq_pkg::ST_RANGE;
               end else begin
                  shadow_front = shadow_front + 1'b1;
                  shadow_count = shadow_count - 1'b1;
               end
            end
            deq_pkg::KIND_REMOVE_BACK: begin
               if (shadow_count == '0) begin
                  predicted.status = deq_pkg::ST_RANGE;
               end else begin
                  shadow_count = shadow_count - 1'b1;
               end
            end
            default: begin
               predicted.status = deq_pkg::ST_RANGE;
            end
         endcase
         predicted.occupancy = shadow_count;
         expected_replies.push_back(predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            $error("response transfer with no request outstanding");
            mismatch_count++;
         end else begin
            predicted = expected_replies.pop_front();
            observed.status = rsp_status;
            observed.read_word = rsp_read_word;
            observed.occupancy = rsp_occupancy;
            compare_field("status", deq_pkg::WORD_WIDTH'(predicted.status),
                          deq_pkg::WORD_WIDTH'(observed.status));
            compare_field("read_word", predicted.read_word, observed.read_word);
            compare_field("occupancy", deq_pkg::WORD_WIDTH'(predicted.occupancy),
                          deq_pkg::WORD_WIDTH'(observed.occupancy));
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("double_ended_queue_indexed_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [deq_pkg::KIND_W-1:0] kind,
                               input logic [deq_pkg::WORD_WIDTH-1:0] value,
                               input logic [deq_pkg::POS_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      req_position <= position;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic test_empty_queue;
      send_request(deq_pkg::KIND_READ, 32'h1234_5678, '0);
      send_request(deq_pkg::KIND_READ, '0, '1);
      send_request(deq_pkg::KIND_REMOVE_FRONT, '1, '0);
      send_request(deq_pkg::KIND_REMOVE_BACK, '0, '1);
   endtask

   task automatic test_unknown_kinds;
      send_request(KIND_UNUSED_LO, '1, '1);
      send_request(KIND_UNUSED_HI, '0, '0);
   endtask

   // Inserting at the front after the appends wraps the front slot around.
   task automatic test_fill_to_capacity;
      send_request(deq_pkg::KIND_APPEND_BACK, '0, '0);
      send_request(deq_pkg::KIND_APPEND_BACK, '1, '1);
      for (int i = 0; i < 6; i++) begin
         send_request(deq_pkg::KIND_APPEND_BACK, $urandom, deq_pkg::POS_W'($urandom));
      end
      send_request(deq_pkg::KIND_INSERT_FRONT, 32'hA5A5_5A5A, '0);
      send_request(deq_pkg::KIND_INSERT_FRONT, '1, '1);
      for (int i = 0; i < 6; i++) begin
         send_request(deq_pkg::KIND_INSERT_FRONT, $urandom, deq_pkg::POS_W'($urandom));
      end
   endtask

   task automatic test_full_queue;
      send_request(deq_pkg::KIND_APPEND_BACK, 32'hDEAD_0001, '0);
      send_request(deq_pkg::KIND_INSERT_FRONT, 32'hDEAD_0002, '0);
      send_request(deq_pkg::KIND_READ, '0, '0);
      send_request(deq_pkg::KIND_READ, '0, deq_pkg::POS_W'(deq_pkg::DEPTH - 1));
   endtask

   // Traffic alternates between runs that tend to fill the queue and runs
   // that tend to drain it, so both the full and the empty state recur.
   task automatic test_mixed_traffic(input int idle_pct, input int stall_pct,
                                     input int item_count);
      int pick;
      int run_left;
      bit filling;
      logic [deq_pkg::KIND_W-1:0] kind;
      logic [deq_pkg::WORD_WIDTH-1:0] value;
      run_left = 0;
      filling = 1'b0;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < item_count; i++) begin
         if (run_left == 0) begin
            filling = !filling;
            run_left = $urandom_range(70, 20);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < 4) begin
            kind = deq_pkg::KIND_W'($urandom_range(int'(KIND_UNUSED_HI),
                                                   int'(KIND_UNUSED_LO)));
         end else if (pick < 34) begin
            kind = deq_pkg::KIND_READ;
         end else if (pick < (filling ? 79 : 49)) begin
            kind = $urandom_range(1) ? deq_pkg::KIND_INSERT_FRONT
                                     : deq_pkg::KIND_APPEND_BACK;
         end else begin
            kind = $urandom_range(1) ? deq_pkg::KIND_REMOVE_FRONT
                                     : deq_pkg::KIND_REMOVE_BACK;
         end
         case ($urandom_range(9))
            0: value = '0;
            1: value = '1;
            default: value = $urandom;
         endcase
         send_request(kind, value, deq_pkg::POS_W'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_unknown_kinds();
      test_fill_to_capacity();
      test_full_queue();
      test_mixed_traffic(0, 0, 450);
      test_mixed_traffic(86, 0, 450);
      test_mixed_traffic(0, 86, 450);
      test_mixed_traffic(21, 21, 450);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("double_ended_queue_indexed_core regression: pass");
      end else begin
         $display("double_ended_queue_indexed_core regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_indexed_core.sv
bench/tb.sv
